[hdl/bsg_pkg.sv]
`default_nettype none

package bsg_pkg;

    // frame geometry and store layout
    localparam int PIXELS  = 65536;
    localparam int MEM_AW  = $clog2(PIXELS);
    localparam int ADDR_W  = 16;
    localparam int CH_W    = 8;
    localparam int BKG_W   = 3 * CH_W;
    localparam int CNT_W   = 8;
    localparam int WORD_W  = BKG_W + CNT_W;

    // config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // bt.601 luma in 14-bit fixed point
    localparam int           LUMA_W     = 22;
    localparam logic [21:0]  LUMA_B     = 22'd1868;
    localparam logic [21:0]  LUMA_G     = 22'd9617;
    localparam logic [21:0]  LUMA_R     = 22'd4899;
    localparam logic [21:0]  LUMA_ROUND = 22'd8192;

    // blend arithmetic
    localparam logic [8:0]  BLEND_ONE   = 9'd256;
    localparam logic [15:0] BLEND_ROUND = 16'd128;
    localparam logic [7:0]  CNT_MAX     = 8'hFF;

    typedef enum logic
    {
        KIND_PROCESS = 1'b0,
        KIND_LOAD    = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_COLOR_MODE       = 3'd0,
        CFG_DIFF_THRESHOLD   = 3'd1,
        CFG_BLEND_WEIGHT     = 3'd2,
        CFG_SELECTIVE_ENABLE = 3'd3,
        CFG_GHOST_ENABLE     = 3'd4,
        CFG_GHOST_LIMIT      = 3'd5
    } cfg_idx_t;

    typedef struct packed
    {
        logic       color_mode;
        logic [7:0] diff_threshold;
        logic [8:0] blend_weight;
        logic       selective_enable;
        logic       ghost_enable;
        logic [7:0] ghost_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        color_mode:       1'b0,
        diff_threshold:   8'd30,
        blend_weight:     9'd0,
        selective_enable: 1'b0,
        ghost_enable:     1'b0,
        ghost_limit:      8'd0
    };

    // result of the read-modify-write stage
    typedef struct packed
    {
        logic              fg;
        logic [WORD_W-1:0] word;
    } upd_t;

    function automatic logic [8:0] clamp_alpha(input logic [8:0] weight);
        clamp_alpha = (weight > BLEND_ONE) ? BLEND_ONE : weight;
    endfunction

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        absdiff8 = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

[hdl/bsg_bkg_ram.sv]
`default_nettype none

module bsg_bkg_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 32
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/bsg_update.sv]
`default_nettype none

module bsg_update (
    input  wire bsg_pkg::cfg_t                     cfg,
    input  wire bsg_pkg::kind_t                    kind,
    input  wire logic [bsg_pkg::BKG_W-1:0]         pix,
    input  wire logic [2:0][15:0]                  pa,
    input  wire logic [bsg_pkg::WORD_W-1:0]        word,
    output bsg_pkg::upd_t                          upd
);

    logic [2:0][7:0]                pc;
    logic [2:0][7:0]                bc;
    logic [2:0][7:0]                blended;
    logic [2:0][16:0]               mix;
    logic [2:0]                     over;
    logic [8:0]                     inv;
    logic                           fg;
    logic [bsg_pkg::BKG_W-1:0]      bkg_blend;
    logic [bsg_pkg::BKG_W-1:0]      bkg_new;
    logic [7:0]                     cnt;
    logic [7:0]                     cnt_inc;
    logic [7:0]                     cnt_new;
    logic                           ghost_hit;

    // (256 - alpha) weight of the old background
    assign inv = bsg_pkg::BLEND_ONE - bsg_pkg::clamp_alpha(cfg.blend_weight);

    for (genvar c = 0; c < 3; c++)
    begin : g_ch
        assign pc[c]      = pix[8*c +: 8];
        assign bc[c]      = word[8*c +: 8];
        assign over[c]    = bsg_pkg::absdiff8(pc[c], bc[c]) > cfg.diff_threshold;
        assign mix[c]     = {1'b0, pa[c]} + ({8'b0, inv} * {9'b0, bc[c]});
        assign blended[c] = mix[c][15:8];
    end

    assign fg = over[0] | (cfg.color_mode & (over[1] | over[2]));

    always_comb
    begin
        if (cfg.selective_enable && fg)
        begin
            if (cfg.color_mode)
            begin
                bkg_blend = {blended[2], blended[1], blended[0]};
            end
            else
            begin
                bkg_blend = {bc[2], bc[1], blended[0]};
            end
        end
        else
        begin
            bkg_blend = word[bsg_pkg::BKG_W-1:0];
        end
    end

    // saturating persistence counter
    assign cnt     = word[bsg_pkg::WORD_W-1:bsg_pkg::BKG_W];
    assign cnt_inc = !fg ? 8'd0 : ((cnt == bsg_pkg::CNT_MAX) ? bsg_pkg::CNT_MAX : cnt + 8'd1);
    assign ghost_hit = cfg.ghost_enable && (cnt_inc > cfg.ghost_limit);

    always_comb
    begin
        if (ghost_hit)
        begin
            bkg_new = cfg.color_mode ? pix : {bkg_blend[23:8], pix[7:0]};
            cnt_new = 8'd0;
        end
        else
        begin
            bkg_new = bkg_blend;
            cnt_new = cfg.ghost_enable ? cnt_inc : cnt;
        end
    end

    always_comb
    begin
        if (kind == bsg_pkg::KIND_LOAD)
        begin
            upd.fg   = 1'b0;
            upd.word = {8'd0, pix};
        end
        else
        begin
            upd.fg   = fg;
            upd.word = {cnt_new, bkg_new};
        end
    end

endmodule

`default_nettype wire

[hdl/background_subtraction_ghost_update.sv]
`default_nettype none

// Per-pixel background subtraction with selective blending and ghost removal.
// One word is taken per clock while the output side does not stall, and every
// word gives one result word. The pipeline has four stages plus the output
// register: stage 1 holds the input and the background read, stage 2 the luma
// products, stage 3 the converted pixel, stage 4 the read-modify-write of the
// store, and then the output register. Background and persistence counter of
// a pixel share one 32-bit word of a single-port-write, registered-read memory;
// back-to-back words for the same pixel are served by forwarding the stage 4
// write into every younger stage, so the sustained rate stays one word per
// clock whatever the address pattern, while the output side does not stall.
// Store entries hold nothing useful until a load word writes them (that also
// clears the counter), so there is no clearing pass after reset. The user must
// write configuration through the plain write port only while the pipeline is
// empty; the block itself does not enforce this.
module background_subtraction_ghost_update (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [bsg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bsg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             kind,
    input  wire logic [bsg_pkg::ADDR_W-1:0]       pixel_addr,
    input  wire logic [7:0]                       blue,
    input  wire logic [7:0]                       green,
    input  wire logic [7:0]                       red,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [bsg_pkg::ADDR_W-1:0]            out_addr,
    output logic                                  foreground
);

    // configuration registers
    bsg_pkg::cfg_t cfg_reg;

    // stage valids and flow control
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic out_valid_reg;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;
    logic rdy_out;

    // stage 1: input word, background read in flight
    bsg_pkg::kind_t                 s1_kind_reg;
    logic [bsg_pkg::ADDR_W-1:0]     s1_addr_reg;
    logic                           s1_in_range_reg;
    logic [7:0]                     s1_blue_reg;
    logic [7:0]                     s1_green_reg;
    logic [7:0]                     s1_red_reg;
    logic                           s1_fwd_valid_reg;
    logic                           s1_fwd_valid_next;
    logic [bsg_pkg::WORD_W-1:0]     s1_fwd_word_reg;
    logic [bsg_pkg::WORD_W-1:0]     s1_fwd_word_next;
    logic [bsg_pkg::ADDR_W-1:0]     s1_addr_next;

    // stage 2: luma products
    bsg_pkg::kind_t                 s2_kind_reg;
    logic [bsg_pkg::ADDR_W-1:0]     s2_addr_reg;
    logic                           s2_in_range_reg;
    logic [7:0]                     s2_blue_reg;
    logic [7:0]                     s2_green_reg;
    logic [7:0]                     s2_red_reg;
    logic [bsg_pkg::LUMA_W-1:0]     s2_prod_b_reg;
    logic [bsg_pkg::LUMA_W-1:0]     s2_prod_g_reg;
    logic [bsg_pkg::LUMA_W-1:0]     s2_prod_r_reg;
    logic [bsg_pkg::WORD_W-1:0]     s2_word_reg;
    logic [bsg_pkg::WORD_W-1:0]     s2_word_next;
    logic [bsg_pkg::ADDR_W-1:0]     s2_addr_next;

    // stage 3: converted pixel
    bsg_pkg::kind_t                 s3_kind_reg;
    logic [bsg_pkg::ADDR_W-1:0]     s3_addr_reg;
    logic                           s3_in_range_reg;
    logic [bsg_pkg::BKG_W-1:0]      s3_pix_reg;
    logic [bsg_pkg::WORD_W-1:0]     s3_word_reg;
    logic [bsg_pkg::WORD_W-1:0]     s3_word_next;
    logic [bsg_pkg::ADDR_W-1:0]     s3_addr_next;
    logic [bsg_pkg::LUMA_W-1:0]     luma_sum;
    logic [bsg_pkg::BKG_W-1:0]      pix_conv;

    // stage 4: read-modify-write
    bsg_pkg::kind_t                 s4_kind_reg;
    logic [bsg_pkg::ADDR_W-1:0]     s4_addr_reg;
    logic                           s4_in_range_reg;
    logic [bsg_pkg::BKG_W-1:0]      s4_pix_reg;
    logic [2:0][15:0]               s4_pa_reg;
    logic [2:0][15:0]               pa_calc;
    logic [bsg_pkg::WORD_W-1:0]     s4_word_reg;
    logic [bsg_pkg::WORD_W-1:0]     s4_word_next;
    logic [bsg_pkg::ADDR_W-1:0]     s4_addr_next;
    logic [8:0]                     alpha;
    bsg_pkg::upd_t                  upd;

    // output register
    logic [bsg_pkg::ADDR_W-1:0]     out_addr_reg;
    logic                           foreground_reg;

    // store port
    logic                           mem_we;
    logic [bsg_pkg::WORD_W-1:0]     ram_rdata;

    // hits of the stage 4 write on the address each stage holds after this edge
    logic hit1;
    logic hit2;
    logic hit3;
    logic hit4;

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= bsg_pkg::CFG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (bsg_pkg::cfg_idx_t'(cfg_index))
                bsg_pkg::CFG_COLOR_MODE:       cfg_reg.color_mode       <= cfg_data[0];
                bsg_pkg::CFG_DIFF_THRESHOLD:   cfg_reg.diff_threshold   <= cfg_data[7:0];
                bsg_pkg::CFG_BLEND_WEIGHT:     cfg_reg.blend_weight     <= cfg_data[8:0];
                bsg_pkg::CFG_SELECTIVE_ENABLE: cfg_reg.selective_enable <= cfg_data[0];
                bsg_pkg::CFG_GHOST_ENABLE:     cfg_reg.ghost_enable     <= cfg_data[0];
                bsg_pkg::CFG_GHOST_LIMIT:      cfg_reg.ghost_limit      <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // flow control: a stage loads when it is empty or its word moves on
    // ---------------------------------------------------------------
    assign rdy_out  = !out_valid_reg | !out_stall;
    assign rdy4     = !s4_valid_reg | rdy_out;
    assign rdy3     = !s3_valid_reg | rdy4;
    assign rdy2     = !s2_valid_reg | rdy3;
    assign rdy1     = !s1_valid_reg | rdy2;
    assign in_stall = !rdy1;

    // the stage 4 word writes the store exactly once, as it leaves
    assign mem_we = s4_valid_reg & rdy_out & s4_in_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            s1_fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (rdy_out)
            begin
                out_valid_reg <= s4_valid_reg;
            end
            s1_fwd_valid_reg <= s1_fwd_valid_next;
        end
    end

    // ---------------------------------------------------------------
    // forwarding: every younger stage snoops the store write
    // ---------------------------------------------------------------
    assign s1_addr_next = rdy1 ? pixel_addr  : s1_addr_reg;
    assign s2_addr_next = rdy2 ? s1_addr_reg : s2_addr_reg;
    assign s3_addr_next = rdy3 ? s2_addr_reg : s3_addr_reg;
    assign s4_addr_next = rdy4 ? s3_addr_reg : s4_addr_reg;

    assign hit1 = mem_we && (s1_addr_next == s4_addr_reg);
    assign hit2 = mem_we && (s2_addr_next == s4_addr_reg);
    assign hit3 = mem_we && (s3_addr_next == s4_addr_reg);
    assign hit4 = mem_we && (s4_addr_next == s4_addr_reg);

    // stage 1 waits on the store read, so it only remembers a newer write
    assign s1_fwd_valid_next = hit1 | (!rdy1 & s1_fwd_valid_reg);
    assign s1_fwd_word_next  = hit1 ? upd.word : s1_fwd_word_reg;

    always_comb
    begin
        s2_word_next = s2_word_reg;
        if (rdy2)
        begin
            s2_word_next = s1_fwd_valid_reg ? s1_fwd_word_reg : ram_rdata;
        end
        if (hit2)
        begin
            s2_word_next = upd.word;
        end
    end

    always_comb
    begin
        s3_word_next = rdy3 ? s2_word_reg : s3_word_reg;
        if (hit3)
        begin
            s3_word_next = upd.word;
        end
    end

    always_comb
    begin
        s4_word_next = rdy4 ? s3_word_reg : s4_word_reg;
        if (hit4)
        begin
            s4_word_next = upd.word;
        end
    end

    // ---------------------------------------------------------------
    // datapath
    // ---------------------------------------------------------------
    // luma sum and color packing
    assign luma_sum = s2_prod_b_reg + s2_prod_g_reg + s2_prod_r_reg + bsg_pkg::LUMA_ROUND;
    assign pix_conv = cfg_reg.color_mode ? {s2_red_reg, s2_green_reg, s2_blue_reg}
                                         : {16'd0, luma_sum[21:14]};

    // alpha * pix + round, the half of the blend that does not need the store
    assign alpha = bsg_pkg::clamp_alpha(cfg_reg.blend_weight);
    for (genvar c = 0; c < 3; c++)
    begin : g_pa
        assign pa_calc[c] = ({7'd0, alpha} * {8'd0, s3_pix_reg[8*c +: 8]})
                            + bsg_pkg::BLEND_ROUND;
    end

    always_ff @(posedge clk)
    begin
        s1_fwd_word_reg <= s1_fwd_word_next;
        s2_word_reg     <= s2_word_next;
        s3_word_reg     <= s3_word_next;
        s4_word_reg     <= s4_word_next;
        s1_addr_reg     <= s1_addr_next;
        s2_addr_reg     <= s2_addr_next;
        s3_addr_reg     <= s3_addr_next;
        s4_addr_reg     <= s4_addr_next;

        if (rdy1)
        begin
            s1_kind_reg     <= bsg_pkg::kind_t'(kind);
            s1_in_range_reg <= (int'(pixel_addr) < bsg_pkg::PIXELS);
            s1_blue_reg     <= blue;
            s1_green_reg    <= green;
            s1_red_reg      <= red;
        end
        if (rdy2)
        begin
            s2_kind_reg     <= s1_kind_reg;
            s2_in_range_reg <= s1_in_range_reg;
            s2_blue_reg     <= s1_blue_reg;
            s2_green_reg    <= s1_green_reg;
            s2_red_reg      <= s1_red_reg;
            s2_prod_b_reg   <= bsg_pkg::LUMA_B * {14'd0, s1_blue_reg};
            s2_prod_g_reg   <= bsg_pkg::LUMA_G * {14'd0, s1_green_reg};
            s2_prod_r_reg   <= bsg_pkg::LUMA_R * {14'd0, s1_red_reg};
        end
        if (rdy3)
        begin
            s3_kind_reg     <= s2_kind_reg;
            s3_in_range_reg <= s2_in_range_reg;
            s3_pix_reg      <= pix_conv;
        end
        if (rdy4)
        begin
            s4_kind_reg     <= s3_kind_reg;
            s4_in_range_reg <= s3_in_range_reg;
            s4_pix_reg      <= s3_pix_reg;
            s4_pa_reg       <= pa_calc;
        end
        if (rdy_out)
        begin
            out_addr_reg   <= s4_addr_reg;
            foreground_reg <= upd.fg & s4_in_range_reg;
        end
    end

    // compare, blend and ghost counter on the forwarded store word
    bsg_update u_update (
        .cfg  (cfg_reg),
        .kind (s4_kind_reg),
        .pix  (s4_pix_reg),
        .pa   (s4_pa_reg),
        .word (s4_word_reg),
        .upd  (upd)
    );

    // background (low 24 bits) and persistence counter (high 8 bits)
    bsg_bkg_ram #(
        .DEPTH (bsg_pkg::PIXELS),
        .AW    (bsg_pkg::MEM_AW),
        .DW    (bsg_pkg::WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (s4_addr_reg[bsg_pkg::MEM_AW-1:0]),
        .wdata (upd.word),
        .re    (rdy1),
        .raddr (pixel_addr[bsg_pkg::MEM_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign out_addr   = out_addr_reg;
    assign foreground = foreground_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // a result word only appears after stage 4 held one
    a_out_from_s4: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s4_valid_reg))
        else $error("result word without a stage 4 word");

    // a load word reports background
    a_load_bkg: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && rdy_out && s4_kind_reg == bsg_pkg::KIND_LOAD) |=> !foreground)
        else $error("load word reported foreground");

    // back-to-back words for one pixel see the write of the older word
    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && s3_valid_reg && s3_addr_reg == s4_addr_reg)
        |=> (s4_word_reg == $past(upd.word)))
        else $error("store write not forwarded to the next word");

    // a gray load clears the counter and upper background bytes
    a_gray_load: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && s4_kind_reg == bsg_pkg::KIND_LOAD && !cfg_reg.color_mode)
        |-> (upd.word[bsg_pkg::WORD_W-1:8] == '0))
        else $error("gray load left stale upper bits");

endmodule

`default_nettype wire

[test/tb_top.sv]
`default_nettype none

module tb_top;

    // run length guard, far above the slowest legal run
    localparam int CYCLE_LIMIT = 500000;
    // results after which the receiver holds off for one long stretch
    localparam int LONG_HOLD_AT = 600;
    localparam int LONG_HOLD_LEN = 400;
    localparam int PHASES = 10;

    // one expected result word
    typedef struct packed
    {
        logic [bsg_pkg::ADDR_W-1:0] addr;
        logic                       fg;
    } fg_word_t;

    // tracks background and persistence per pixel and the foreground words still due
    class fg_tracker;
        bsg_pkg::cfg_t regs;
        logic [23:0]   bkg_mem [bsg_pkg::PIXELS];
        logic [7:0]    persist [bsg_pkg::PIXELS];
        fg_word_t      fg_due[$];
        int            errors;

        function new();
            regs = bsg_pkg::CFG_RESET;
            errors = 0;
        endfunction

        function void set_reg(bsg_pkg::cfg_idx_t idx,
                              logic [bsg_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                bsg_pkg::CFG_COLOR_MODE:       regs.color_mode = val[0];
                bsg_pkg::CFG_DIFF_THRESHOLD:   regs.diff_threshold = val[7:0];
                bsg_pkg::CFG_BLEND_WEIGHT:     regs.blend_weight = val[8:0];
                bsg_pkg::CFG_SELECTIVE_ENABLE: regs.selective_enable = val[0];
                bsg_pkg::CFG_GHOST_ENABLE:     regs.ghost_enable = val[0];
                bsg_pkg::CFG_GHOST_LIMIT:      regs.ghost_limit = val[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return fg_due.size();
        endfunction

        // bt.601 in 14-bit fixed point
        function logic [7:0] luma_of(logic [7:0] b, logic [7:0] g, logic [7:0] r);
            int unsigned acc;
            acc = 1868 * b + 9617 * g + 4899 * r + 8192;
            return 8'(acc >> 14);
        endfunction

        function logic [7:0] blend_ch(logic [7:0] p, logic [7:0] q, logic [8:0] a);
            int unsigned acc;
            acc = a * p + (256 - a) * q + 128;
            return 8'(acc >> 8);
        endfunction

        // updates the pixel's entry and queues the foreground bit it gives
        function void note_pixel(bsg_pkg::kind_t k, logic [bsg_pkg::ADDR_W-1:0] addr,
                                 logic [7:0] b, logic [7:0] g, logic [7:0] r);
            logic [23:0] pix;
            logic [23:0] bkg;
            logic [23:0] nb;
            logic [8:0]  a;
            logic [7:0]  pc;
            logic [7:0]  bc;
            logic [7:0]  d;
            logic        fg;
            int          nch;
            int unsigned cnt;
            fg = 1'b0;
            pix = regs.color_mode ? {r, g, b} : {16'd0, luma_of(b, g, r)};
            if (k == bsg_pkg::KIND_LOAD)
            begin
                bkg_mem[addr] = pix;
                persist[addr] = 8'd0;
            end
            else
            begin
                bkg = bkg_mem[addr];
                nch = regs.color_mode ? 3 : 1;
                a = (regs.blend_weight > 9'd256) ? 9'd256 : regs.blend_weight;
                for (int c = 0; c < nch; c++)
                begin
                    pc = pix[8*c +: 8];
                    bc = bkg[8*c +: 8];
                    d = (pc > bc) ? pc - bc : bc - pc;
                    if (d > regs.diff_threshold)
                        fg = 1'b1;
                end
                if (regs.selective_enable && fg)
                begin
                    // gray mode keeps the upper bytes as stored
                    nb = regs.color_mode ? 24'd0 : {bkg[23:8], 8'd0};
                    for (int c = 0; c < nch; c++)
                        nb[8*c +: 8] = blend_ch(pix[8*c +: 8], bkg[8*c +: 8], a);
                    bkg = nb;
                end
                if (regs.ghost_enable)
                begin
                    cnt = persist[addr];
                    if (fg)
                        cnt = (cnt < 255) ? cnt + 1 : 255;
                    else
                        cnt = 0;
                    if (cnt > regs.ghost_limit)
                    begin
                        bkg = regs.color_mode ? pix : {bkg[23:8], pix[7:0]};
                        cnt = 0;
                    end
                    persist[addr] = 8'(cnt);
                end
                bkg_mem[addr] = bkg;
            end
            fg_due.push_back('{addr: addr, fg: fg});
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] %s", $time, what);
        endtask

        task check_word(logic [bsg_pkg::ADDR_W-1:0] addr, logic fg);
            fg_word_t want;
            if (fg_due.size() == 0)
            begin
                report($sformatf("word for pixel %0d with nothing due", addr));
                return;
            end
            want = fg_due.pop_front();
            if (addr !== want.addr)
                report($sformatf("out_addr %0d, due %0d", addr, want.addr));
            if (fg !== want.fg)
                report($sformatf("foreground %b at pixel %0d, due %b", fg, want.addr, want.fg));
        endtask
    endclass

    // dut signals, all inputs known from time zero
    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [bsg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bsg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           kind = 1'b0;
    logic [bsg_pkg::ADDR_W-1:0]     pixel_addr = '0;
    logic [7:0]                     blue = '0;
    logic [7:0]                     green = '0;
    logic [7:0]                     red = '0;
    logic                           out_stall = 1'b0;
    wire                            in_stall;
    wire                            out_valid;
    wire [bsg_pkg::ADDR_W-1:0]      out_addr;
    wire                            foreground;

    fg_tracker tracker = new();

    // stimulus bookkeeping: which pixels hold a background, and roughly what
    logic [23:0]                base_pix [int];
    logic [bsg_pkg::ADDR_W-1:0] all_loaded[$];
    logic [bsg_pkg::ADDR_W-1:0] hot[$];
    int                         burst_left = 0;
    bit                         steady = 1'b0;

    // receiver bookkeeping
    int  words_out = 0;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    int  window_left = 0;
    int  stall_mode = 0;
    int  cycles = 0;

    background_subtraction_ghost_update u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .pixel_addr (pixel_addr),
        .blue       (blue),
        .green      (green),
        .red        (red),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_addr   (out_addr),
        .foreground (foreground)
    );

    always #1 clk = ~clk;

    // run guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: check every accepted word, then pick next cycle's stall
    always @(posedge clk)
    begin
        logic stall_next;
        if (out_valid && !out_stall)
        begin
            tracker.check_word(out_addr, foreground);
            words_out++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            stall_next = 1'b1;
        end
        else if (!long_hold_done && words_out >= LONG_HOLD_AT)
        begin
            // one long hold-off so the pipe fills and pushes back on the sender
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_LEN;
            stall_next = 1'b1;
        end
        else
        begin
            // windows of differing stall density, including none at all
            if (window_left == 0)
            begin
                window_left = $urandom_range(8, 80);
                stall_mode = $urandom_range(0, 3);
            end
            window_left--;
            case (stall_mode)
                0: stall_next = 1'b0;
                1: stall_next = ($urandom_range(0, 3) == 0);
                2: stall_next = ($urandom_range(0, 4) < 3);
                default: stall_next = ~out_stall;
            endcase
        end
        out_stall <= stall_next;
    end

    // offer one word and hold it until accepted; valid stays high afterwards
    task automatic send_word(input bsg_pkg::kind_t k,
                             input logic [bsg_pkg::ADDR_W-1:0] addr,
                             input logic [23:0] rgb);
        in_valid <= 1'b1;
        kind <= k;
        pixel_addr <= addr;
        {red, green, blue} <= rgb;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_pixel(k, addr, rgb[7:0], rgb[15:8], rgb[23:16]);
    endtask

    task automatic hold_off(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic load_word(input logic [bsg_pkg::ADDR_W-1:0] addr,
                             input logic [23:0] rgb);
        if (!base_pix.exists(addr))
            all_loaded.push_back(addr);
        base_pix[addr] = rgb;
        send_word(bsg_pkg::KIND_LOAD, addr, rgb);
    endtask

    // bursts of random length with random gaps, unless the phase runs steady
    task automatic pace();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            if (!steady)
                hold_off($urandom_range(1, 10));
        end
        burst_left--;
    endtask

    // stop offering, wait for every due word, then idle before returning
    task automatic drain();
        hold_off(1);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input bsg_pkg::cfg_idx_t idx,
                             input logic [bsg_pkg::CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        tracker.set_reg(idx, val);
    endtask

    // all six registers, only while the pipe is empty
    task automatic apply_settings(input bsg_pkg::cfg_t s);
        write_reg(bsg_pkg::CFG_COLOR_MODE, bsg_pkg::CFG_DATA_W'(s.color_mode));
        write_reg(bsg_pkg::CFG_DIFF_THRESHOLD, bsg_pkg::CFG_DATA_W'(s.diff_threshold));
        write_reg(bsg_pkg::CFG_BLEND_WEIGHT, s.blend_weight);
        write_reg(bsg_pkg::CFG_SELECTIVE_ENABLE, bsg_pkg::CFG_DATA_W'(s.selective_enable));
        write_reg(bsg_pkg::CFG_GHOST_ENABLE, bsg_pkg::CFG_DATA_W'(s.ghost_enable));
        write_reg(bsg_pkg::CFG_GHOST_LIMIT, bsg_pkg::CFG_DATA_W'(s.ghost_limit));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic bsg_pkg::cfg_t roll_settings();
        bsg_pkg::cfg_t s;
        s.color_mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: s.diff_threshold = 8'd0;
            1: s.diff_threshold = 8'd255;
            default: s.diff_threshold = 8'($urandom_range(0, 60));
        endcase
        case ($urandom_range(0, 4))
            0: s.blend_weight = 9'd0;
            1: s.blend_weight = 9'd256;
            2: s.blend_weight = 9'd511;
            default: s.blend_weight = 9'($urandom_range(0, 511));
        endcase
        s.selective_enable = 1'($urandom_range(0, 1));
        s.ghost_enable = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
            0: s.ghost_limit = 8'd255;
            1: s.ghost_limit = 8'd254;
            default: s.ghost_limit = 8'($urandom_range(0, 8));
        endcase
        return s;
    endfunction

    // mostly near the loaded color so both foreground and background show up
    function automatic logic [23:0] pick_pixel(input logic [bsg_pkg::ADDR_W-1:0] addr);
        logic [23:0] base;
        logic [23:0] pix;
        int          v;
        base = base_pix[addr];
        case ($urandom_range(0, 3))
            0: pix = 24'($urandom);
            1:
            begin
                for (int c = 0; c < 3; c++)
                    pix[8*c +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    v = int'(base[8*c +: 8]) + $urandom_range(0, 80) - 40;
                    pix[8*c +: 8] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
                end
            end
        endcase
        return pix;
    endfunction

    initial
    begin
        bsg_pkg::cfg_t              s;
        logic [bsg_pkg::ADDR_W-1:0] addr;
        int                         hot_n;
        int                         n_items;
        int                         load_pct;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default settings, gray mode, field extremes
        load_word(16'd0, 24'hFFFFFF);
        load_word(16'hFFFF, 24'h000000);
        load_word(16'h5A5A, 24'h1280F0);
        load_word(16'hA5A5, 24'hFF0000);
        send_word(bsg_pkg::KIND_PROCESS, 16'd0, 24'hFFFFFF);
        send_word(bsg_pkg::KIND_PROCESS, 16'hFFFF, 24'hFFFFFF);
        send_word(bsg_pkg::KIND_PROCESS, 16'h5A5A, 24'h1280F0);
        send_word(bsg_pkg::KIND_PROCESS, 16'hA5A5, 24'h000000);
        send_word(bsg_pkg::KIND_PROCESS, 16'd0, 24'hE0E0E0);
        drain();

        // color mode on gray-loaded entries, threshold and weight at the top
        apply_settings('{color_mode: 1'b1, diff_threshold: 8'd255, blend_weight: 9'd511,
                         selective_enable: 1'b1, ghost_enable: 1'b1, ghost_limit: 8'd0});
        send_word(bsg_pkg::KIND_PROCESS, 16'h5A5A, 24'h1280F0);
        load_word(16'h00FF, 24'hFF00FF);
        send_word(bsg_pkg::KIND_PROCESS, 16'h00FF, 24'h00FF00);
        drain();

        // zero threshold, full blend, instant ghost replacement
        apply_settings('{color_mode: 1'b1, diff_threshold: 8'd0, blend_weight: 9'd256,
                         selective_enable: 1'b1, ghost_enable: 1'b1, ghost_limit: 8'd0});
        send_word(bsg_pkg::KIND_PROCESS, 16'h00FF, 24'h00FF00);
        send_word(bsg_pkg::KIND_PROCESS, 16'h00FF, 24'h00FF00);
        send_word(bsg_pkg::KIND_PROCESS, 16'h00FF, 24'h00FF01);
        load_word(16'hFF00, 24'h808080);
        send_word(bsg_pkg::KIND_PROCESS, 16'hFF00, 24'h808081);
        drain();

        // gray mode reading color-loaded entries, no blend, ghost off
        apply_settings('{color_mode: 1'b0, diff_threshold: 8'd10, blend_weight: 9'd0,
                         selective_enable: 1'b1, ghost_enable: 1'b0, ghost_limit: 8'd255});
        send_word(bsg_pkg::KIND_PROCESS, 16'hFF00, 24'h303030);
        send_word(bsg_pkg::KIND_PROCESS, 16'd0, 24'h000000);
        send_word(bsg_pkg::KIND_PROCESS, 16'hFFFF, 24'h000000);
        load_word(16'h1234, 24'h55AA33);
        send_word(bsg_pkg::KIND_PROCESS, 16'h1234, 24'h55AA34);
        drain();

        // random phases, each with its own settings and hot pixels
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                // one pixel kept foreground long enough to saturate its counter
                s = '{color_mode: 1'b1, diff_threshold: 8'd0, blend_weight: 9'd0,
                      selective_enable: 1'b0, ghost_enable: 1'b1, ghost_limit: 8'd255};
            else if (p == 1)
                // same pixel, limit just below saturation
                s = '{color_mode: 1'b1, diff_threshold: 8'd0, blend_weight: 9'd511,
                      selective_enable: 1'b1, ghost_enable: 1'b1, ghost_limit: 8'd254};
            else
                s = roll_settings();
            apply_settings(s);

            steady = ($urandom_range(0, 2) == 0);
            burst_left = 0;
            load_pct = (p == 0) ? 0 : 15;
            n_items = (p == 0) ? 400 : 110;

            if (p != 1)
            begin
                hot.delete();
                hot_n = (p == 0) ? 1 : $urandom_range(2, 12);
                for (int i = 0; i < hot_n; i++)
                begin
                    addr = 16'($urandom_range(0, 65535));
                    pace();
                    load_word(addr, 24'($urandom));
                    hot.push_back(addr);
                end
            end

            for (int i = 0; i < n_items; i++)
            begin
                pace();
                if ($urandom_range(0, 99) < load_pct)
                begin
                    if ($urandom_range(0, 1))
                        addr = hot[$urandom_range(0, hot.size() - 1)];
                    else
                        addr = 16'($urandom_range(0, 65535));
                    load_word(addr, 24'($urandom));
                end
                else
                begin
                    if ($urandom_range(0, 99) < 85)
                        addr = hot[$urandom_range(0, hot.size() - 1)];
                    else
                        addr = all_loaded[$urandom_range(0, all_loaded.size() - 1)];
                    send_word(bsg_pkg::KIND_PROCESS, addr, pick_pixel(addr));
                end
            end
            // sender waits for every due word before the next settings
            drain();
        end

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hdl/bsg_pkg.sv
hdl/bsg_bkg_ram.sv
hdl/bsg_update.sv
hdl/background_subtraction_ghost_update.sv
test/tb_top.sv
